### src/mplg_pkg.sv
package mplg_pkg;

  // Field and counter widths
  localparam int PT_W   = 12;  // phase elapsed ticks
  localparam int RT_W   = 9;   // ramp elapsed ticks
  localparam int LVL_W  = 8;   // brightness level
  localparam int IDX_W  = 3;   // level table index
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NUM_W  = LVL_W + RT_W;  // ramp numerator terms

  // Guard phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PREP  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;
  localparam logic [1:0] PH_REL   = 2'd3;

  // Input word kinds
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REL_NOW    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT_LEVEL = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

  localparam logic [PT_W-1:0] PREP_DELAY_RST = 12'd50;
  localparam logic [PT_W-1:0] REL_DELAY_RST  = 12'd100;

  // Dim target levels
  localparam logic [LVL_W-1:0] LEVEL_TABLE [8] = '{
    8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28
  };

  // Result fields except the dim brightness, which the ramp path supplies
  typedef struct packed {
    logic [1:0]       guard_phase;
    logic             motor_ready;
    logic             dim_active;
    logic             mute_write;
    logic             mute_value;
    logic             saved_valid;
    logic             muted_before;
    logic [LVL_W-1:0] test_level;
  } res_t;

  // Ramp update request: new dim = (prod_a + prod_b) / RAMP_TICKS
  typedef struct packed {
    logic             wr;
    logic [NUM_W-1:0] prod_a;
    logic [NUM_W-1:0] prod_b;
  } dim_req_t;

endpackage

### src/mplg_ctrl.sv
module mplg_ctrl #(
  parameter int RAMP_TICKS  = 300,
  parameter int LEVEL_COUNT = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [mplg_pkg::KIND_W-1:0]      kind,
  input  logic                             muted_now,
  input  logic [mplg_pkg::LVL_W-1:0]       brightness_now,
  input  logic                             cfg_wr,
  input  logic [mplg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mplg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             s1_valid,
  output mplg_pkg::res_t                   s1_res,
  output mplg_pkg::dim_req_t               s1_dim
);
  import mplg_pkg::*;

  localparam logic [RT_W-1:0]  RAMP_K    = RT_W'(RAMP_TICKS);
  localparam logic [IDX_W:0]   LVL_CNT   = (IDX_W + 1)'(LEVEL_COUNT);
  localparam logic [IDX_W-1:0] IDX_RST   = (LEVEL_COUNT > 2) ? IDX_W'(2) : '0;

  logic                  guard_mode_r;
  logic [PT_W-1:0]       prepare_delay_r, release_delay_r;
  logic [1:0]            phase_r, phase_nxt;
  logic [PT_W-1:0]       phase_ticks_r, phase_ticks_nxt;
  logic [RT_W-1:0]       ramp_ticks_r, ramp_ticks_nxt;
  logic                  ramping_up_r, ramping_up_nxt;
  logic                  saved_flag_r, saved_flag_nxt;
  logic                  saved_mute_r, saved_mute_nxt;
  logic [LVL_W-1:0]      saved_level_r, saved_level_nxt;
  logic [IDX_W-1:0]      level_index_r, level_index_nxt;

  logic                  s1_valid_r;
  res_t                  s1_res_r, res_nxt;
  dim_req_t              s1_dim_r, dim_nxt;

  logic                  in_fire;
  logic                  strobe, strobe_val, do_restore;
  logic                  dim_wr;
  logic [LVL_W-1:0]      dim_from, dim_to, sel, req_lvl;
  logic [RT_W-1:0]       dim_k, k_clamp, pt_unused_rt;
  logic [PT_W-1:0]       pt_inc;
  logic [RT_W-1:0]       rt_inc;

  assign in_fire = en & in_valid;
  assign sel     = LEVEL_TABLE[level_index_r];
  assign pt_inc  = (phase_ticks_r == '1) ? phase_ticks_r : phase_ticks_r + 1'b1;
  assign rt_inc  = (ramp_ticks_r == '1) ? ramp_ticks_r : ramp_ticks_r + 1'b1;
  assign req_lvl = saved_flag_r ? saved_level_r : brightness_now;

  always_comb begin
    phase_nxt       = phase_r;
    phase_ticks_nxt = phase_ticks_r;
    ramp_ticks_nxt  = ramp_ticks_r;
    ramping_up_nxt  = ramping_up_r;
    saved_flag_nxt  = saved_flag_r;
    saved_mute_nxt  = saved_mute_r;
    saved_level_nxt = saved_level_r;
    level_index_nxt = level_index_r;
    strobe          = 1'b0;
    strobe_val      = 1'b0;
    do_restore      = 1'b0;
    dim_wr          = 1'b0;
    dim_from        = saved_level_r;
    dim_to          = sel;
    dim_k           = '0;
    pt_unused_rt    = '0;
    case (kind)
      KIND_TICK: begin
        phase_ticks_nxt = pt_inc;
        ramp_ticks_nxt  = rt_inc;
        if (phase_r == PH_PREP) begin
          if (guard_mode_r) begin
            dim_wr   = 1'b1;
            dim_from = saved_level_r;
            dim_to   = sel;
            dim_k    = rt_inc;
            if (pt_inc >= prepare_delay_r && rt_inc >= RAMP_K) phase_nxt = PH_READY;
          end else if (pt_inc >= prepare_delay_r) begin
            phase_nxt = PH_READY;
          end
        end else if (phase_r == PH_REL && pt_inc >= release_delay_r) begin
          if (guard_mode_r) begin
            // Start the upward ramp on the first tick that reaches the release delay
            pt_unused_rt = ramping_up_r ? rt_inc : '0;
            if (!ramping_up_r) begin
              ramping_up_nxt = 1'b1;
              ramp_ticks_nxt = '0;
            end
            dim_wr   = 1'b1;
            dim_from = sel;
            dim_to   = saved_level_r;
            dim_k    = pt_unused_rt;
            if (pt_unused_rt >= RAMP_K) do_restore = 1'b1;
          end else begin
            do_restore = 1'b1;
          end
        end
      end
      KIND_REQUEST: begin
        if (phase_r != PH_PREP && phase_r != PH_READY) begin
          if (!guard_mode_r) begin
            if (!saved_flag_r) begin
              saved_mute_nxt = muted_now;
              saved_flag_nxt = 1'b1;
            end
            if (!muted_now) begin
              strobe     = 1'b1;
              strobe_val = 1'b1;
            end
          end else begin
            saved_level_nxt = req_lvl;
            saved_flag_nxt  = 1'b1;
            dim_wr          = 1'b1;
            dim_from        = req_lvl;
            dim_k           = '0;
            ramp_ticks_nxt  = '0;
            ramping_up_nxt  = 1'b0;
          end
          phase_nxt       = PH_PREP;
          phase_ticks_nxt = '0;
        end
      end
      KIND_RELEASE: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt       = PH_REL;
          phase_ticks_nxt = '0;
          ramping_up_nxt  = 1'b0;
        end
      end
      KIND_REL_NOW: begin
        if (phase_r != PH_IDLE) do_restore = 1'b1;
      end
      KIND_NEXT_LEVEL: begin
        level_index_nxt = ({1'b0, level_index_r} + 1'b1 >= LVL_CNT) ? '0
                                                                    : level_index_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (do_restore) begin
      if (saved_flag_r) begin
        if (!guard_mode_r) begin
          strobe     = 1'b1;
          strobe_val = saved_mute_r;
        end
        saved_flag_nxt = 1'b0;
      end
      phase_nxt = PH_IDLE;
    end
  end

  // Ramp numerator terms; clamp k so that a finished ramp lands on its target
  assign k_clamp = (dim_k >= RAMP_K) ? RAMP_K : dim_k;

  always_comb begin
    res_nxt.guard_phase  = phase_nxt;
    res_nxt.motor_ready  = (phase_nxt == PH_READY);
    res_nxt.dim_active   = guard_mode_r & (phase_nxt != PH_IDLE);
    res_nxt.mute_write   = strobe;
    res_nxt.mute_value   = strobe_val;
    res_nxt.saved_valid  = saved_flag_nxt;
    res_nxt.muted_before = saved_flag_nxt & saved_mute_nxt;
    res_nxt.test_level   = LEVEL_TABLE[level_index_nxt];
    dim_nxt.wr           = in_fire & dim_wr;
    dim_nxt.prod_a       = NUM_W'(dim_from) * NUM_W'(RAMP_K - k_clamp);
    dim_nxt.prod_b       = NUM_W'(dim_to) * NUM_W'(k_clamp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_mode_r    <= 1'b0;
      prepare_delay_r <= PREP_DELAY_RST;
      release_delay_r <= REL_DELAY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_MODE:    if (phase_r == PH_IDLE) guard_mode_r <= cfg_wdata[0];
        CFG_PREP:    prepare_delay_r <= cfg_wdata;
        CFG_RELEASE: release_delay_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      phase_ticks_r <= '0;
      ramp_ticks_r  <= '0;
      ramping_up_r  <= 1'b0;
      saved_flag_r  <= 1'b0;
      saved_mute_r  <= 1'b0;
      saved_level_r <= '0;
      level_index_r <= IDX_RST;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      ramp_ticks_r  <= ramp_ticks_nxt;
      ramping_up_r  <= ramping_up_nxt;
      saved_flag_r  <= saved_flag_nxt;
      saved_mute_r  <= saved_mute_nxt;
      saved_level_r <= saved_level_nxt;
      level_index_r <= level_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_dim_r   <= '0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s1_dim_r   <= dim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_res_r <= res_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_res   = s1_res_r;
  assign s1_dim   = s1_dim_r;

endmodule

### src/mplg_ramp.sv
module mplg_ramp #(
  parameter int RAMP_TICKS = 300
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  mplg_pkg::dim_req_t          s1_dim,
  output logic [mplg_pkg::LVL_W-1:0]  dim_brightness
);
  import mplg_pkg::*;

  // Exact reciprocal for numerators below 2**NUM_W
  localparam int SH     = NUM_W + $clog2(RAMP_TICKS);
  localparam int MUL_W  = NUM_W + 2;
  localparam int PROD_W = NUM_W + MUL_W;
  localparam int MUL_C  = ((2 ** SH) + RAMP_TICKS - 1) / RAMP_TICKS;

  logic                 s2_wr_r;
  logic [PROD_W-1:0]    q_prod_r, q_prod_nxt;
  logic [NUM_W-1:0]     sum_w;
  logic [LVL_W-1:0]     cur_dim_r;

  assign sum_w      = s1_dim.prod_a + s1_dim.prod_b;
  assign q_prod_nxt = PROD_W'(sum_w) * PROD_W'(MUL_W'(MUL_C));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_wr_r <= 1'b0;
    end else if (en) begin
      s2_wr_r <= s1_dim.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_prod_r <= q_prod_nxt;
  end

  // Hold the last written brightness; items that do not touch it repeat it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_dim_r <= '0;
    end else if (en && s2_wr_r) begin
      cur_dim_r <= q_prod_r[SH +: LVL_W];
    end
  end

  assign dim_brightness = cur_dim_r;

endmodule

### src/motor_power_led_guard.sv
// An accepted word is registered in stages 1, 2 and 3 in turn; stage 3 drives the out_ side.
// Throughput: one word per cycle; the ramp divide is a two-stage reciprocal multiply.
// All three stages advance together and stall only while out_tvalid waits on out_tready.
// Reset: synchronous, active low on rst_n; phase idle, counters and saved state cleared,
// level index at its default, delays back to 50 and 100 ticks, full-mute mode.
module motor_power_led_guard #(
  parameter int RAMP_TICKS  = 300,
  parameter int LEVEL_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] muted_now, [8:1] brightness_now, [15:9] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] guard_phase, [2] motor_ready, [3] dim_active,
                                  // [11:4] dim_brightness, [12] mute_write,
                                  // [13] mute_value, [14] saved_valid,
                                  // [15] muted_before, [23:16] test_level
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import mplg_pkg::*;

  logic              en;
  logic              s1_valid;
  res_t              s1_res;
  dim_req_t          s1_dim;
  logic              s2_valid_r;
  res_t              s2_res_r;
  logic              out_valid_r;
  res_t              out_res_r;
  logic [LVL_W-1:0]  dim_brightness;

  // Advance the whole pipe whenever the output slot is free or being drained
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Registers are always writable; a mode write lands only while the guard is idle
  assign cfg_ready = 1'b1;

  // Stage 1: phase sequencing and ramp numerator terms
  mplg_ctrl #(
    .RAMP_TICKS  (RAMP_TICKS),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_tvalid),
    .kind           (in_tuser),
    .muted_now      (in_tdata[0]),
    .brightness_now (in_tdata[8:1]),
    .cfg_wr         (cfg_valid & cfg_ready),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .s1_valid       (s1_valid),
    .s1_res         (s1_res),
    .s1_dim         (s1_dim)
  );

  // Stages 2 and 3: divide by the ramp length, hold the override brightness
  mplg_ramp #(
    .RAMP_TICKS (RAMP_TICKS)
  ) u_ramp (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .s1_dim         (s1_dim),
    .dim_brightness (dim_brightness)
  );

  // Carry the remaining result fields alongside the divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_res_r  <= s1_res;
      out_res_r <= s2_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.test_level,
                       out_res_r.muted_before,
                       out_res_r.saved_valid,
                       out_res_r.mute_value,
                       out_res_r.mute_write,
                       dim_brightness,
                       out_res_r.dim_active,
                       out_res_r.motor_ready,
                       out_res_r.guard_phase};

endmodule
